>>> rtl/core/vhps_pkg.sv
// vhps_pkg: shared types and constants for the VBR header parser and seek block.
// Used by every module under rtl/core but vhps_ram; depends on nothing.
package vhps_pkg;

   // Header magic words and flag bit positions
   localparam logic [31:0] MAGIC_XING = 32'h5869_6E67;
   localparam logic [31:0] MAGIC_INFO = 32'h496E_666F;
   localparam int FLAG_FRAMES = 0;
   localparam int FLAG_BYTES  = 1;
   localparam int FLAG_TOC    = 2;
   localparam int FLAG_SCALE  = 3;

   // Table of contents geometry
   localparam int TOC_ENTRIES   = 100;
   localparam int TOC_AW        = 7;
   localparam int TOC_LAST      = 99;
   localparam int TOC_END_VALUE = 256;

   // Restoring divider for the seek percent
   localparam int DIV_W     = 56;
   localparam int DIV_CNT_W = 6;
   localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIV_W - 1);

   // Percent scale: ms * 100 with 16 fraction bits
   localparam int PCT_SCALE     = 100;
   localparam int SCALE_DIVISOR = 100;

   // Divide by 100 one 16-bit digit per cycle: multiply by ceil(2^30 / 100), shift 30
   localparam logic [23:0] SCALE_RECIP = 24'd10737419;
   localparam int SCALE_SHIFT = 30;
   localparam logic [DIV_CNT_W-1:0] SCALE_LAST = DIV_CNT_W'(2);

   localparam logic [32:0] MAX33 = {33{1'b1}};

   // Register indexes of the configuration port
   localparam logic [1:0] CSR_STREAM_LENGTH = 2'd0;
   localparam logic [1:0] CSR_FALLBACK_LEN  = 2'd1;
   localparam logic [1:0] CSR_ID3_LENGTH    = 2'd2;

   // Parse status codes
   typedef enum logic [1:0] {
      ST_PARSING = 2'd0,
      ST_VALID   = 2'd1,
      ST_INVALID = 2'd2
   } pstat_type;

   // Controller states
   typedef enum logic [3:0] {
      S_IDLE,
      S_RESP,
      S_PCT_DIV,
      S_TOC_RD_A,
      S_TOC_RD_B,
      S_INTERP,
      S_MUL_LO,
      S_MUL_HI,
      S_SCALE_LOAD,
      S_SCALE_DIV,
      S_FINISH
   } state_type;

   // Commands from controller to datapath
   typedef struct packed {
      logic byte_take;
      logic seek_load;
      logic div_step;
      logic toc_rd_b;
      logic interp;
      logic mul_lo;
      logic mul_hi;
      logic scale_load;
      logic scale_step;
      logic finish;
   } ctl_type;

   // Status from datapath to controller
   typedef struct packed {
      logic div_done;
      logic scale_done;
      logic hdr_valid;
   } sts_type;

endpackage

>>> rtl/core/vhps_ram.sv
// vhps_ram: generic single-write, single-read RAM with registered read data.
// Stand-alone; no package needed.
module vhps_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 100
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // Write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

>>> rtl/core/vhps_ctrl.sv
// vhps_ctrl: controller state machine sequencing byte items and seek items.
// Depends on vhps_pkg; drives the commands of vhps_dp.
module vhps_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic              req_op,
   input  vhps_pkg::sts_type sts,
   output logic              busy,
   output logic              rsp_valid,
   output vhps_pkg::ctl_type ctl
);

   vhps_pkg::state_type state_ff, state_in;

   // Hold state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= vhps_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands
   always_comb begin
      state_in  = state_ff;
      ctl       = '0;
      busy      = 1'b1;
      rsp_valid = 1'b0;
      case (state_ff)
         vhps_pkg::S_IDLE: begin
            busy = 1'b0;
            if (start) begin
               if (req_op) begin
                  ctl.seek_load = 1'b1;
                  state_in      = vhps_pkg::S_PCT_DIV;
               end else begin
                  ctl.byte_take = 1'b1;
                  state_in      = vhps_pkg::S_RESP;
               end
            end
         end
         vhps_pkg::S_PCT_DIV: begin
            ctl.div_step = 1'b1;
            if (sts.div_done) begin
               state_in = sts.hdr_valid ? vhps_pkg::S_TOC_RD_A : vhps_pkg::S_MUL_LO;
            end
         end
         vhps_pkg::S_TOC_RD_A: begin
            state_in = vhps_pkg::S_TOC_RD_B;
         end
         vhps_pkg::S_TOC_RD_B: begin
            ctl.toc_rd_b = 1'b1;
            state_in     = vhps_pkg::S_INTERP;
         end
         vhps_pkg::S_INTERP: begin
            ctl.interp = 1'b1;
            state_in   = vhps_pkg::S_MUL_LO;
         end
         vhps_pkg::S_MUL_LO: begin
            ctl.mul_lo = 1'b1;
            state_in   = vhps_pkg::S_MUL_HI;
         end
         vhps_pkg::S_MUL_HI: begin
            ctl.mul_hi = 1'b1;
            state_in   = sts.hdr_valid ? vhps_pkg::S_FINISH : vhps_pkg::S_SCALE_LOAD;
         end
         vhps_pkg::S_SCALE_LOAD: begin
            ctl.scale_load = 1'b1;
            state_in       = vhps_pkg::S_SCALE_DIV;
         end
         vhps_pkg::S_SCALE_DIV: begin
            ctl.scale_step = 1'b1;
            if (sts.scale_done) begin
               state_in = vhps_pkg::S_FINISH;
            end
         end
         vhps_pkg::S_FINISH: begin
            ctl.finish = 1'b1;
            state_in   = vhps_pkg::S_RESP;
         end
         vhps_pkg::S_RESP: begin
            rsp_valid = 1'b1;
            state_in  = vhps_pkg::S_IDLE;
         end
         default: begin
            state_in = vhps_pkg::S_IDLE;
         end
      endcase
   end

endmodule

>>> rtl/core/vhps_dp.sv
// vhps_dp: datapath with header parse registers, TOC memory, percent divider,
// divide by 100, split multiplier and offset saturation. Depends on vhps_pkg, vhps_ram.
module vhps_dp (
   input  logic                clock,
   input  logic                reset,
   input  vhps_pkg::ctl_type   ctl,
   output vhps_pkg::sts_type   sts,
   input  logic                req_first_byte,
   input  logic [7:0]          req_data_byte,
   input  logic [31:0]         req_seek_ms,
   input  logic                csr_we,
   input  logic [1:0]          csr_index,
   input  logic [31:0]         csr_wdata,
   output logic [1:0]          rsp_parse_status,
   output logic [31:0]         rsp_frame_count,
   output logic [31:0]         rsp_data_length,
   output logic signed [32:0]  rsp_vbr_scale,
   output logic [32:0]         rsp_seek_offset
);

   // Configuration registers
   logic [31:0] len_ff, fallback_ff;
   logic [28:0] id3_ff;

   // Parse state
   logic [6:0]          pos_ff, pos_in;
   logic [3:0]          flags_ff, flags_in;
   logic [31:0]         shift_ff, shift_in;
   vhps_pkg::pstat_type status_ff, status_in;
   logic [31:0]         frames_ff, frames_in;
   logic [31:0]         bytes_ff, bytes_in;
   logic [32:0]         scale_ff, scale_in;
   logic                toc_we;
   logic [vhps_pkg::TOC_AW-1:0] toc_waddr;

   // Seek datapath
   logic [vhps_pkg::DIV_W-1:0]     div_q_ff;
   logic [32:0]                    div_rem_ff;
   logic [31:0]                    div_d_ff;
   logic [vhps_pkg::DIV_CNT_W-1:0] div_cnt_ff;
   logic [32:0]                    div_trial;
   logic [33:0]                    div_diff;
   logic [38:0]                    ms_scaled;
   logic [31:0]                    len_eff;

   logic [22:0]                    scl_v, scl_qd, scl_rem;
   logic [46:0]                    scl_prod;
   logic [15:0]                    scl_q;

   logic [39:0]                    ip;
   logic                           beyond, at_last;
   logic [vhps_pkg::TOC_AW-1:0]    toc_a, toc_raddr;
   logic [vhps_pkg::DIV_W-1:0]     frac;
   logic [7:0]                     toc_rdata, fa_ff;
   logic signed [8:0]              near_diff;
   logic signed [16:0]             near_frac;
   logic signed [25:0]             near_prod, near_sum;
   logic [8:0]                     far_tail;
   logic [64:0]                    far_prod;
   logic [63:0]                    fx_in, fx_ff;

   logic [63:0]                    mul_a;
   logic [31:0]                    mul_b, mul_half;
   logic [63:0]                    mul_part;
   logic [95:0]                    prod_ff;

   logic                           off_sat;
   logic [32:0]                    off_raw, off_ff;
   logic [33:0]                    off_sum;

   // Write configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff      <= 32'd1;
         fallback_ff <= '0;
         id3_ff      <= '0;
      end else if (csr_we) begin
         case (csr_index)
            vhps_pkg::CSR_STREAM_LENGTH: len_ff      <= csr_wdata;
            vhps_pkg::CSR_FALLBACK_LEN:  fallback_ff <= csr_wdata;
            vhps_pkg::CSR_ID3_LENGTH:    id3_ff      <= csr_wdata[28:0];
            default: ;
         endcase
      end
   end

   // Parse one header byte: restart on a first byte, then walk the header layout
   always_comb begin
      logic [7:0] p8;
      logic [7:0] q;
      p8        = '0;
      q         = 8'd8;
      pos_in    = pos_ff;
      flags_in  = flags_ff;
      shift_in  = shift_ff;
      status_in = status_ff;
      frames_in = frames_ff;
      bytes_in  = bytes_ff;
      scale_in  = scale_ff;
      toc_we    = 1'b0;
      toc_waddr = '0;
      if (req_first_byte) begin
         pos_in    = '0;
         flags_in  = '0;
         shift_in  = '0;
         status_in = vhps_pkg::ST_PARSING;
         frames_in = '0;
         bytes_in  = '0;
         scale_in  = '1;
      end
      if (status_in == vhps_pkg::ST_PARSING) begin
         p8       = {1'b0, pos_in};
         shift_in = {shift_in[23:0], req_data_byte};
         if (p8 == 8'd3) begin
            if (shift_in != vhps_pkg::MAGIC_XING && shift_in != vhps_pkg::MAGIC_INFO) begin
               status_in = vhps_pkg::ST_INVALID;
            end
         end else if (p8 == 8'd7) begin
            flags_in = shift_in[3:0];
            if (!flags_in[vhps_pkg::FLAG_FRAMES]) begin
               status_in = vhps_pkg::ST_INVALID;
            end
         end else if (p8 >= 8'd8) begin
            if (p8 == q + 8'd3) begin
               frames_in = shift_in;
               if (shift_in == '0) begin
                  status_in = vhps_pkg::ST_INVALID;
               end
            end
            q = q + 8'd4;
            if (flags_in[vhps_pkg::FLAG_BYTES]) begin
               if (p8 == q + 8'd3) begin
                  bytes_in = shift_in;
               end
               q = q + 8'd4;
            end
            if (flags_in[vhps_pkg::FLAG_TOC]) begin
               if (p8 >= q && p8 < q + 8'(vhps_pkg::TOC_ENTRIES)) begin
                  toc_we    = 1'b1;
                  toc_waddr = 7'(p8 - q);
               end
               q = q + 8'(vhps_pkg::TOC_ENTRIES);
            end
            if (flags_in[vhps_pkg::FLAG_SCALE]) begin
               if (p8 == q + 8'd3) begin
                  scale_in = {1'b0, shift_in};
               end
               q = q + 8'd4;
            end
            if (status_in == vhps_pkg::ST_PARSING && p8 + 8'd1 == q) begin
               status_in = vhps_pkg::ST_VALID;
            end
         end
         pos_in = pos_in + 7'd1;
      end
   end

   // Hold parse state
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff    <= '0;
         flags_ff  <= '0;
         shift_ff  <= '0;
         status_ff <= vhps_pkg::ST_INVALID;
         frames_ff <= '0;
         bytes_ff  <= '0;
         scale_ff  <= '1;
      end else if (ctl.byte_take) begin
         pos_ff    <= pos_in;
         flags_ff  <= flags_in;
         shift_ff  <= shift_in;
         status_ff <= status_in;
         frames_ff <= frames_in;
         bytes_ff  <= bytes_in;
         scale_ff  <= scale_in;
      end
   end

   // Table of contents: point a, then a+1 on the second read unless a is the last entry
   assign ip      = div_q_ff[vhps_pkg::DIV_W-1:16];
   assign beyond  = ip > 40'(vhps_pkg::TOC_LAST);
   assign at_last = ip >= 40'(vhps_pkg::TOC_LAST);
   assign toc_a   = beyond ? 7'(vhps_pkg::TOC_LAST) : ip[6:0];
   assign frac    = beyond ? div_q_ff - (56'(vhps_pkg::TOC_LAST) << 16)
                           : {40'b0, div_q_ff[15:0]};
   assign toc_raddr = (ctl.toc_rd_b && !at_last) ? toc_a + 7'd1 : toc_a;

   vhps_ram #(
      .WIDTH (8),
      .DEPTH (vhps_pkg::TOC_ENTRIES)
   ) u_toc (
      .clock   (clock),
      .wr_en   (ctl.byte_take && toc_we),
      .wr_addr (toc_waddr),
      .wr_data (req_data_byte),
      .rd_addr (toc_raddr),
      .rd_data (toc_rdata)
   );

   // Interpolate between entries, or extrapolate toward the end value
   assign near_diff = $signed({1'b0, toc_rdata}) - $signed({1'b0, fa_ff});
   assign near_frac = $signed({1'b0, frac[15:0]});
   assign near_prod = near_diff * near_frac;
   assign near_sum  = $signed({2'b0, fa_ff, 16'b0}) + near_prod;
   assign far_tail  = 9'(vhps_pkg::TOC_END_VALUE) - {1'b0, fa_ff};
   assign far_prod  = {56'b0, far_tail} * {9'b0, frac};
   assign fx_in     = at_last ? ({40'b0, fa_ff, 16'b0} + far_prod[63:0])
                              : {40'b0, near_sum[23:0]};

   // Divider step: shift in one dividend bit and try the subtract
   assign div_trial = {div_rem_ff[31:0], div_q_ff[vhps_pkg::DIV_W-1]};
   assign div_diff  = {1'b0, div_trial} - {2'b0, div_d_ff};
   assign ms_scaled = {7'b0, req_seek_ms} * 39'(vhps_pkg::PCT_SCALE);
   assign len_eff   = (len_ff == '0) ? 32'd1 : len_ff;

   // Divide by 100, top 16-bit digit first: remainder and digit over the reciprocal
   assign scl_v    = {div_rem_ff[6:0], div_q_ff[47:32]};
   assign scl_prod = {24'b0, scl_v} * {23'b0, vhps_pkg::SCALE_RECIP};
   assign scl_q    = scl_prod[vhps_pkg::SCALE_SHIFT +: 16];
   assign scl_qd   = {7'b0, scl_q} * 23'(vhps_pkg::SCALE_DIVISOR);
   assign scl_rem  = scl_v - scl_qd;

   // Split 64x32 multiply: one 32x32 product per cycle
   assign mul_a    = sts.hdr_valid ? fx_ff : {{(64-vhps_pkg::DIV_W){1'b0}}, div_q_ff};
   assign mul_b    = sts.hdr_valid ? bytes_ff : fallback_ff;
   assign mul_half = ctl.mul_hi ? mul_a[63:32] : mul_a[31:0];
   assign mul_part = {32'b0, mul_half} * {32'b0, mul_b};

   // Offset: take integer bytes, add tag length, saturate
   always_comb begin
      if (sts.hdr_valid) begin
         off_sat = |prod_ff[95:57];
         off_raw = prod_ff[56:24];
      end else begin
         off_sat = (|prod_ff[95:64]) || (|div_q_ff[vhps_pkg::DIV_W-1:33]);
         off_raw = div_q_ff[32:0];
      end
      off_sum = {1'b0, off_raw} + {5'b0, id3_ff};
   end

   // Advance the seek datapath
   always_ff @(posedge clock) begin
      if (ctl.seek_load) begin
         div_q_ff   <= {1'b0, ms_scaled, 16'b0};
         div_rem_ff <= '0;
         div_d_ff   <= len_eff;
         div_cnt_ff <= '0;
      end else if (ctl.scale_load) begin
         div_q_ff   <= {8'b0, prod_ff[63:16]};
         div_rem_ff <= '0;
         div_cnt_ff <= '0;
      end else if (ctl.scale_step) begin
         div_rem_ff <= {26'b0, scl_rem[6:0]};
         div_q_ff   <= {8'b0, div_q_ff[31:0], scl_q};
         div_cnt_ff <= div_cnt_ff + {{(vhps_pkg::DIV_CNT_W-1){1'b0}}, 1'b1};
      end else if (ctl.div_step) begin
         if (!div_diff[33]) begin
            div_rem_ff <= div_diff[32:0];
            div_q_ff   <= {div_q_ff[vhps_pkg::DIV_W-2:0], 1'b1};
         end else begin
            div_rem_ff <= div_trial;
            div_q_ff   <= {div_q_ff[vhps_pkg::DIV_W-2:0], 1'b0};
         end
         div_cnt_ff <= div_cnt_ff + {{(vhps_pkg::DIV_CNT_W-1){1'b0}}, 1'b1};
      end
      if (ctl.toc_rd_b) begin
         fa_ff <= toc_rdata;
      end
      if (ctl.interp) begin
         fx_ff <= fx_in;
      end
      if (ctl.mul_lo) begin
         prod_ff <= {32'b0, mul_part};
      end else if (ctl.mul_hi) begin
         prod_ff <= prod_ff + {mul_part, 32'b0};
      end
      if (ctl.byte_take) begin
         off_ff <= '0;
      end else if (ctl.finish) begin
         off_ff <= (off_sat || off_sum[33]) ? vhps_pkg::MAX33 : off_sum[32:0];
      end
   end

   assign sts.div_done   = div_cnt_ff == vhps_pkg::DIV_LAST;
   assign sts.scale_done = div_cnt_ff == vhps_pkg::SCALE_LAST;
   assign sts.hdr_valid  = status_ff == vhps_pkg::ST_VALID;

   assign rsp_parse_status = status_ff;
   assign rsp_frame_count  = frames_ff;
   assign rsp_data_length  = bytes_ff;
   assign rsp_vbr_scale    = $signed(scale_ff);
   assign rsp_seek_offset  = off_ff;

endmodule

>>> rtl/core/vbr_header_parse_and_seek.sv
// A header byte item gives its result strobe in the cycle after accept; the block takes
// no new item until its result strobe has gone. A seek with a valid header also reads
// the table and interpolates; a seek on the fallback path does neither.
// Seek time is set by the 56-step restoring divider for the percent; the fallback
// path adds a three-digit divide by 100. Results cannot be stalled. Synchronous
// active-high reset: idle, status invalid, scale -1; the table is not cleared.
module vbr_header_parse_and_seek (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic               req_op,
   input  logic               req_first_byte,
   input  logic [7:0]         req_data_byte,
   input  logic [31:0]        req_seek_ms,
   output logic               rsp_valid,
   output logic [1:0]         rsp_parse_status,
   output logic [31:0]        rsp_frame_count,
   output logic [31:0]        rsp_data_length,
   output logic signed [32:0] rsp_vbr_scale,
   output logic [32:0]        rsp_seek_offset,
   input  logic               csr_we,
   input  logic [1:0]         csr_index,
   input  logic [31:0]        csr_wdata
);

   vhps_pkg::ctl_type ctl;
   vhps_pkg::sts_type sts;

   vhps_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .req_op    (req_op),
      .sts       (sts),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .ctl       (ctl)
   );

   vhps_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .ctl              (ctl),
      .sts              (sts),
      .req_first_byte   (req_first_byte),
      .req_data_byte    (req_data_byte),
      .req_seek_ms      (req_seek_ms),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .rsp_parse_status (rsp_parse_status),
      .rsp_frame_count  (rsp_frame_count),
      .rsp_data_length  (rsp_data_length),
      .rsp_vbr_scale    (rsp_vbr_scale),
      .rsp_seek_offset  (rsp_seek_offset)
   );

endmodule

>>> rtl/core/vhps_chk.sv
// vhps_chk: port-level checks on the VBR header parser and seek block.
// Depends on vhps_pkg; bound to vbr_header_parse_and_seek below.
module vhps_chk (
   input logic               clock,
   input logic               reset,
   input logic               start,
   input logic               busy,
   input logic               rsp_valid,
   input logic [1:0]         rsp_parse_status,
   input logic signed [32:0] rsp_vbr_scale
);

   // Accept always leads to a busy cycle
   assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("no busy after accept");

   // Result strobe lasts one cycle
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe longer than one cycle");

   // A result only shows while the item is still held
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy)
      else $error("result while idle");

   // Status is a defined code
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_parse_status == vhps_pkg::ST_PARSING ||
                     rsp_parse_status == vhps_pkg::ST_VALID ||
                     rsp_parse_status == vhps_pkg::ST_INVALID))
      else $error("bad parse status");

   // A negative scale can only be the absent marker
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_vbr_scale[32] |-> rsp_vbr_scale == -33'sd1)
      else $error("bad scale value");

endmodule

bind vbr_header_parse_and_seek vhps_chk u_vhps_chk (
   .clock            (clock),
   .reset            (reset),
   .start            (start),
   .busy             (busy),
   .rsp_valid        (rsp_valid),
   .rsp_parse_status (rsp_parse_status),
   .rsp_vbr_scale    (rsp_vbr_scale)
);

>>> tb/sv/vbr_header_parse_and_seek_checker.sv
// Checker for vbr_header_parse_and_seek: watches the item, result and register ports,
// predicts each result from its own copy of the parse state and compares them.
// Depends on vhps_pkg for the status codes, magic words and register indexes.
module vbr_header_parse_and_seek_checker
   import vhps_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic               busy,
   input  logic               req_op,
   input  logic               req_first_byte,
   input  logic [7:0]         req_data_byte,
   input  logic [31:0]        req_seek_ms,
   input  logic               rsp_valid,
   input  logic [1:0]         rsp_parse_status,
   input  logic [31:0]        rsp_frame_count,
   input  logic [31:0]        rsp_data_length,
   input  logic signed [32:0] rsp_vbr_scale,
   input  logic [32:0]        rsp_seek_offset,
   input  logic               csr_we,
   input  logic [1:0]         csr_index,
   input  logic [31:0]        csr_wdata,
   output int                 fail_count,
   output int                 pending
);

   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] frames;
      logic [31:0] bytes;
      logic [32:0] scale;
      logic [32:0] offset;
   } vbr_answer_t;

   // register copies
   logic [31:0] stream_len;
   logic [31:0] fallback_len;
   logic [28:0] id3_len;

   // parse state copies
   logic [6:0]  hdr_pos;
   logic [3:0]  hdr_flags;
   logic [31:0] shift_word;
   pstat_type   hdr_status;
   logic [31:0] frames_seen;
   logic [31:0] bytes_seen;
   logic [32:0] scale_seen;
   logic [7:0]  toc [TOC_ENTRIES];

   vbr_answer_t answers_due[$];

   assign pending = answers_due.size();

   function automatic logic [63:0] sat_mul(logic [63:0] a, logic [63:0] b);
      logic [127:0] p;
      p = {64'b0, a} * {64'b0, b};
      return (p[127:64] != 0) ? {64{1'b1}} : p[63:0];
   endfunction

   function automatic logic [63:0] sat_add(logic [63:0] a, logic [63:0] b);
      logic [64:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[64] ? {64{1'b1}} : s[63:0];
   endfunction

   // advance the header parse by one payload byte
   function automatic void absorb_byte(logic [7:0] b);
      int p;
      int q;
      p = hdr_pos;
      shift_word = {shift_word[23:0], b};
      if (p == 3) begin
         if (shift_word != MAGIC_XING && shift_word != MAGIC_INFO)
            hdr_status = ST_INVALID;
      end else if (p == 7) begin
         hdr_flags = shift_word[3:0];
         if (!hdr_flags[FLAG_FRAMES])
            hdr_status = ST_INVALID;
      end else if (p >= 8) begin
         if (p == 11) begin
            frames_seen = shift_word;
            if (shift_word == 0)
               hdr_status = ST_INVALID;
         end
         q = 12;
         if (hdr_flags[FLAG_BYTES]) begin
            if (p == q + 3)
               bytes_seen = shift_word;
            q += 4;
         end
         if (hdr_flags[FLAG_TOC]) begin
            if (p >= q && p < q + TOC_ENTRIES)
               toc[p - q] = b;
            q += TOC_ENTRIES;
         end
         if (hdr_flags[FLAG_SCALE]) begin
            if (p == q + 3)
               scale_seen = {1'b0, shift_word};
            q += 4;
         end
         if (hdr_status == ST_PARSING && p + 1 == q)
            hdr_status = ST_VALID;
      end
      hdr_pos = 7'(p + 1);
   endfunction

   // byte offset for a seek in milliseconds
   function automatic logic [32:0] seek_offset(logic [31:0] ms);
      logic [63:0] len;
      logic [63:0] pct;
      logic [63:0] ip;
      logic [63:0] frac;
      logic [63:0] fa;
      logic [63:0] fb;
      logic [63:0] fx;
      logic [63:0] off;
      longint      v;
      int          a;
      len = (stream_len == 0) ? 64'd1 : {32'b0, stream_len};
      pct = ({32'b0, ms} * 64'd6553600) / len;
      if (hdr_status == ST_VALID) begin
         ip = pct >> 16;
         a = (ip > TOC_LAST) ? TOC_LAST : int'(ip);
         frac = pct - (64'(a) << 16);
         fa = {56'b0, toc[a]};
         if (a < TOC_LAST) begin
            fb = {56'b0, toc[a + 1]};
            v = longint'(fa << 16) + (longint'(fb) - longint'(fa)) * longint'(frac);
            fx = v;
         end else begin
            fx = sat_add(fa << 16, sat_mul(64'(TOC_END_VALUE) - fa, frac));
         end
         off = sat_mul(fx, {32'b0, bytes_seen}) >> 24;
      end else begin
         off = sat_mul({32'b0, fallback_len}, pct) / 64'd6553600;
      end
      off = sat_add(off, {35'b0, id3_len});
      return (off > {31'b0, MAX33}) ? MAX33 : off[32:0];
   endfunction

   function automatic vbr_answer_t predict_answer(logic op, logic first, logic [7:0] b,
                                                  logic [31:0] ms);
      vbr_answer_t r;
      r.offset = '0;
      if (!op) begin
         if (first) begin
            hdr_pos = '0;
            hdr_flags = '0;
            shift_word = '0;
            hdr_status = ST_PARSING;
            frames_seen = '0;
            bytes_seen = '0;
            scale_seen = '1;
         end
         if (hdr_status == ST_PARSING)
            absorb_byte(b);
      end else begin
         r.offset = seek_offset(ms);
      end
      r.status = hdr_status;
      r.frames = frames_seen;
      r.bytes = bytes_seen;
      r.scale = scale_seen;
      return r;
   endfunction

   always @(posedge clock) begin
      vbr_answer_t e;
      if (reset) begin
         stream_len <= 32'd1;
         fallback_len <= '0;
         id3_len <= '0;
         hdr_pos = '0;
         hdr_flags = '0;
         shift_word = '0;
         hdr_status = ST_INVALID;
         frames_seen = '0;
         bytes_seen = '0;
         scale_seen = '1;
         answers_due.delete();
      end else begin
         // compare the result against the oldest expectation
         if (rsp_valid) begin
            if (answers_due.size() == 0) begin
               $display("%0t: unexpected result, no item waiting", $time);
               fail_count++;
            end else begin
               e = answers_due.pop_front();
               if (rsp_parse_status !== e.status) begin
                  $display("%0t: parse_status expected %0d actual %0d", $time, e.status,
                           rsp_parse_status);
                  fail_count++;
               end
               if (rsp_frame_count !== e.frames) begin
                  $display("%0t: frame_count expected %h actual %h", $time, e.frames,
                           rsp_frame_count);
                  fail_count++;
               end
               if (rsp_data_length !== e.bytes) begin
                  $display("%0t: data_length expected %h actual %h", $time, e.bytes,
                           rsp_data_length);
                  fail_count++;
               end
               if (rsp_vbr_scale !== e.scale) begin
                  $display("%0t: vbr_scale expected %h actual %h", $time, e.scale,
                           rsp_vbr_scale);
                  fail_count++;
               end
               if (rsp_seek_offset !== e.offset) begin
                  $display("%0t: seek_offset expected %h actual %h", $time, e.offset,
                           rsp_seek_offset);
                  fail_count++;
               end
            end
         end
         // track register writes
         if (csr_we) begin
            case (csr_index)
               CSR_STREAM_LENGTH: stream_len <= csr_wdata;
               CSR_FALLBACK_LEN:  fallback_len <= csr_wdata;
               CSR_ID3_LENGTH:    id3_len <= csr_wdata[28:0];
               default: ;
            endcase
         end
         // predict each accepted item
         if (start && !busy)
            answers_due.push_back(predict_answer(req_op, req_first_byte, req_data_byte,
                                                 req_seek_ms));
      end
   end

   initial fail_count = 0;

endmodule

>>> tb/sv/vbr_header_parse_and_seek_tb.sv
// Testbench top for vbr_header_parse_and_seek: drives header bytes, seeks and
// register writes, and gives the verdict from the checker's failure count.
// Depends on vhps_pkg, the block and vbr_header_parse_and_seek_checker.
module vbr_header_parse_and_seek_tb;
   import vhps_pkg::*;

   localparam int RUN_ITEMS = 700;
   localparam int CYCLE_LIMIT = 3000000;

   logic               clock;
   logic               reset;
   logic               start;
   logic               busy;
   logic               req_op;
   logic               req_first_byte;
   logic [7:0]         req_data_byte;
   logic [31:0]        req_seek_ms;
   logic               rsp_valid;
   logic [1:0]         rsp_parse_status;
   logic [31:0]        rsp_frame_count;
   logic [31:0]        rsp_data_length;
   logic signed [32:0] rsp_vbr_scale;
   logic [32:0]        rsp_seek_offset;
   logic               csr_we;
   logic [1:0]         csr_index;
   logic [31:0]        csr_wdata;
   int                 fail_count;
   int                 pending;

   int          idle_pct;
   int          items_sent;
   int          cycles;
   logic [31:0] cur_len;

   vbr_header_parse_and_seek DUT (.*);
   vbr_header_parse_and_seek_checker u_checker (.*);

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // watchdog
   initial cycles = 0;
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   // offer one item and hold it until accepted
   task automatic send_item(logic op, logic first, logic [7:0] b, logic [31:0] ms);
      while ($urandom_range(99) < idle_pct) begin
         start = 1'b0;
         @(negedge clock);
      end
      start = 1'b1;
      req_op = op;
      req_first_byte = first;
      req_data_byte = b;
      req_seek_ms = ms;
      do @(posedge clock); while (busy);
      @(negedge clock);
      items_sent++;
   endtask

   // hold off until every result is in
   task automatic drain();
      start = 1'b0;
      while (pending != 0)
         @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_reg(logic [1:0] idx, logic [31:0] val);
      drain();
      csr_we = 1'b1;
      csr_index = idx;
      csr_wdata = val;
      if (idx == CSR_STREAM_LENGTH)
         cur_len = val;
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   // seek near the stream length mostly, anywhere sometimes
   task automatic send_seek();
      logic [31:0] ms;
      logic [31:0] span;
      span = (cur_len > 32'hD000_0000) ? 32'hFFFF_FFFF : cur_len + cur_len / 5 + 1;
      case ($urandom_range(9))
         0:       ms = $urandom;
         1:       ms = cur_len;
         2:       ms = '0;
         default: ms = $urandom_range(span, 0);
      endcase
      send_item(1'b1, 1'($urandom_range(1)), 8'($urandom), ms);
   endtask

   // send one header, well formed or broken as asked
   task automatic send_header(logic [3:0] flags, bit good_magic, bit zero_frames, bit cut);
      logic [7:0]  hdr[$];
      logic [31:0] w;
      int          n;
      w = good_magic ? ($urandom_range(1) ? MAGIC_XING : MAGIC_INFO) : $urandom;
      if (!good_magic && (w == MAGIC_XING || w == MAGIC_INFO))
         w = ~w;
      for (int i = 3; i >= 0; i--) hdr.push_back(w[8*i +: 8]);
      w = $urandom;
      w[3:0] = flags;
      for (int i = 3; i >= 0; i--) hdr.push_back(w[8*i +: 8]);
      w = zero_frames ? 32'd0 : ($urandom | 32'd1);
      for (int i = 3; i >= 0; i--) hdr.push_back(w[8*i +: 8]);
      if (flags[FLAG_BYTES]) begin
         w = ($urandom_range(3) == 0) ? 32'($urandom_range(3)) : $urandom;
         for (int i = 3; i >= 0; i--) hdr.push_back(w[8*i +: 8]);
      end
      if (flags[FLAG_TOC]) begin
         n = 0;
         for (int i = 0; i < TOC_ENTRIES; i++) begin
            if ($urandom_range(3) == 0)
               hdr.push_back(8'($urandom));
            else begin
               n = (n + $urandom_range(5) > 255) ? 255 : n + $urandom_range(5);
               hdr.push_back(8'(n));
            end
         end
      end
      if (flags[FLAG_SCALE]) begin
         w = $urandom;
         for (int i = 3; i >= 0; i--) hdr.push_back(w[8*i +: 8]);
      end
      n = cut ? $urandom_range(hdr.size() - 1, 1) : hdr.size() + $urandom_range(2);
      for (int i = 0; i < n; i++)
         send_item(1'b0, i == 0, (i < hdr.size()) ? hdr[i] : 8'($urandom), $urandom);
   endtask

   initial begin
      int pick;
      reset = 1'b1;
      start = 1'b0;
      req_op = 1'b0;
      req_first_byte = 1'b0;
      req_data_byte = '0;
      req_seek_ms = '0;
      csr_we = 1'b0;
      csr_index = CSR_STREAM_LENGTH;
      csr_wdata = '0;
      idle_pct = 0;
      items_sent = 0;
      cur_len = 32'd1;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: seeks on the reset state, then a full header with every part
      send_seek();
      write_reg(CSR_STREAM_LENGTH, 32'd0);
      send_item(1'b1, 1'b0, 8'hFF, 32'hFFFF_FFFF);
      write_reg(CSR_FALLBACK_LEN, 32'hFFFF_FFFF);
      write_reg(CSR_ID3_LENGTH, 32'h1FFF_FFFF);
      send_item(1'b1, 1'b1, 8'h00, 32'hFFFF_FFFF);
      send_item(1'b1, 1'b0, 8'h00, 32'd0);
      write_reg(CSR_STREAM_LENGTH, 32'd240000);
      write_reg(CSR_ID3_LENGTH, 32'd0);
      send_header(4'hF, 1'b1, 1'b0, 1'b0);
      send_item(1'b1, 1'b0, 8'h00, 32'd0);
      send_item(1'b1, 1'b1, 8'h00, 32'd240000);
      send_item(1'b1, 1'b0, 8'h00, 32'd239999);
      send_item(1'b1, 1'b0, 8'h00, 32'hFFFF_FFFF);
      // valid header without a table, bad magic, zero and missing frame counts, a cut header
      send_header(4'h3, 1'b1, 1'b0, 1'b0);
      send_seek();
      send_header(4'hF, 1'b0, 1'b0, 1'b0);
      send_seek();
      send_header(4'h7, 1'b1, 1'b1, 1'b0);
      send_header(4'hE, 1'b1, 1'b0, 1'b0);
      send_item(1'b0, 1'b0, 8'hA5, 32'd0);
      send_header(4'h1, 1'b1, 1'b0, 1'b1);
      send_seek();

      // random: phases of idling and register settings
      pick = 0;
      while (items_sent < RUN_ITEMS) begin
         case ($urandom_range(4))
            0: write_reg(CSR_STREAM_LENGTH, 32'hFFFF_FFFF);
            1: write_reg(CSR_STREAM_LENGTH, $urandom_range(3, 0));
            default: write_reg(CSR_STREAM_LENGTH, $urandom_range(3600000, 1000));
         endcase
         write_reg(CSR_FALLBACK_LEN, ($urandom_range(5) == 0) ? 32'hFFFF_FFFF : $urandom);
         write_reg(CSR_ID3_LENGTH, ($urandom_range(5) == 0) ? 32'h1FFF_FFFF
                                                         : 32'($urandom_range(100000)));
         for (int k = 0; k < 6 && items_sent < RUN_ITEMS; k++) begin
            case (pick % 4)
               0: idle_pct = 0;
               1: idle_pct = 67;
               2: idle_pct = 0;
               default: idle_pct = 14;
            endcase
            pick++;
            case ($urandom_range(9))
               0:       send_header(4'($urandom), $urandom_range(3) != 0,
                                    $urandom_range(5) == 0, 1'($urandom_range(1)));
               1:       send_item(1'b0, 1'($urandom_range(1)), 8'($urandom), $urandom);
               2, 3:    send_header({3'($urandom), 1'b1}, 1'b1, 1'b0,
                                    $urandom_range(4) == 0);
               default: send_seek();
            endcase
            repeat ($urandom_range(3)) send_seek();
         end
      end

      // wait out the last results
      drain();
      repeat (130) @(posedge clock);
      if (fail_count == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule

>>> files.f
rtl/core/vhps_pkg.sv
rtl/core/vhps_ram.sv
rtl/core/vhps_ctrl.sv
rtl/core/vhps_dp.sv
rtl/core/vbr_header_parse_and_seek.sv
rtl/core/vhps_chk.sv
tb/sv/vbr_header_parse_and_seek_checker.sv
tb/sv/vbr_header_parse_and_seek_tb.sv
